// ===== rtl/matrix_product_engine_assert.svh =====
// Assertion macros shared by the matrix product engine modules.
`ifndef MATRIX_PRODUCT_ENGINE_ASSERT_SVH
`define MATRIX_PRODUCT_ENGINE_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define MPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define MPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mpe_pkg.sv =====
// Types, codes and helpers shared by the matrix product engine.
`timescale 1ns / 1ps
package mpe_pkg;

  localparam int MAX_DIM_DEF    = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int SIZE_W = 5;  // width of a size register
  localparam int CFG_W  = 2;  // width of the register index

  localparam logic [CFG_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_W-1:0] CFG_COLS_B    = 2'd2;

  localparam logic [1:0] CMD_WRITE_A = 2'd0;
  localparam logic [1:0] CMD_WRITE_B = 2'd1;
  localparam logic [1:0] CMD_READ_C  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] product_value;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic clear;   // zero the accumulator
    logic mul_en;  // register the product of the read data
    logic acc_en;  // add the shifted product into the accumulator
  } mac_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } seq_state_e;

  // Clamp a size register to the array dimension.
  function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] v, int unsigned max_dim);
    logic [SIZE_W-1:0] r;
    r = v;
    if (int'(v) > int'(max_dim)) begin
      r = SIZE_W'(max_dim);
    end
    return r;
  endfunction

endpackage

// ===== rtl/mpe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mpe_mac.sv =====
// Shared multiply-accumulate unit with Q16.16 rescale and 32-bit saturation.
`timescale 1ns / 1ps
module mpe_mac
  import mpe_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  input  mac_ctl_t              ctl_i,
  output logic signed [31:0]    sum_o,
  output logic                  sat_o
);

  localparam int ELEM_W  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int TERM_W  = PROD_W - 16;
  localparam int ACC_RAW = TERM_W + $clog2(MAX_DIM) + 1;
  localparam int ACC_W   = (ACC_RAW > 33) ? ACC_RAW : 33;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(signed'(32'h7FFF_FFFF));
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(signed'(32'h8000_0000));

  logic signed [ELEM_W-1:0] a_s, b_s;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc_q;

  // Stored values are sign-extended, so the low bits carry the whole value.
  assign a_s  = signed'(a_i[ELEM_W-1:0]);
  assign b_s  = signed'(b_i[ELEM_W-1:0]);
  // Arithmetic shift right by 16: keep the upper product bits.
  assign term = signed'(prod_q[PROD_W-1:16]);

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= a_s * b_s;
    end
    if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (ctl_i.acc_en) begin
      acc_q <= acc_q + ACC_W'(term);
    end
  end

  always_comb begin
    sat_o = 1'b0;
    sum_o = acc_q[31:0];
    if (acc_q > SAT_HI) begin
      sat_o = 1'b1;
      sum_o = 32'sh7FFF_FFFF;
    end else if (acc_q < SAT_LO) begin
      sat_o = 1'b1;
      sum_o = signed'(32'h8000_0000);
    end
  end

endmodule

// ===== rtl/mpe_seq.sv =====
// Sequencer: command decode, store addressing and dot-product stepping.
`timescale 1ns / 1ps
module mpe_seq
  import mpe_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  in_item_t                             in_item_i,
  input  logic [SIZE_W-1:0]                    nr_i,
  input  logic [SIZE_W-1:0]                    nk_i,
  input  logic [SIZE_W-1:0]                    nc_i,
  input  logic                                 out_free_i,
  output logic                                 in_stall_o,
  output logic                                 a_we_o,
  output logic                                 b_we_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   waddr_o,
  output logic                                 rd_en_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   a_raddr_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   b_raddr_o,
  output mac_ctl_t                             mac_ctl_o,
  output logic                                 load_out_o,
  output logic                                 err_o
);

  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int KW     = $clog2(MAX_DIM);
  localparam int CW     = KW + 1;

  seq_state_e state_q, state_d;
  logic [KW-1:0] k_q, k_d;
  logic [3:0]    row_q, row_d, col_q, col_d;
  logic          err_q, err_d;
  logic          rd_v_q, mul_v_q;
  logic          accept, row_in_r, row_in_k, col_in_c, col_in_k, last_k;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign row_in_r = {1'b0, in_item_i.row_index} < nr_i;
  assign row_in_k = {1'b0, in_item_i.row_index} < nk_i;
  assign col_in_c = {1'b0, in_item_i.col_index} < nc_i;
  assign col_in_k = {1'b0, in_item_i.col_index} < nk_i;
  assign last_k   = (CW'(k_q) + CW'(1)) == CW'(nk_i);

  assign waddr_o   = ADDR_W'(ADDR_W'(in_item_i.row_index) * ADDR_W'(MAX_DIM)
                     + ADDR_W'(in_item_i.col_index));
  assign a_raddr_o = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q));
  assign b_raddr_o = ADDR_W'(ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(col_q));

  assign in_stall_o = (state_q != ST_IDLE);
  assign err_o      = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      err_q   <= 1'b0;
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      err_q   <= err_d;
      rd_v_q  <= rd_en_o;
      mul_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    col_q <= col_d;
  end

  always_comb begin
    state_d          = state_q;
    k_d              = k_q;
    row_d            = row_q;
    col_d            = col_q;
    err_d            = err_q;
    a_we_o           = 1'b0;
    b_we_o           = 1'b0;
    rd_en_o          = 1'b0;
    load_out_o       = 1'b0;
    mac_ctl_o.clear  = 1'b0;
    mac_ctl_o.mul_en = rd_v_q;
    mac_ctl_o.acc_en = mul_v_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          row_d = in_item_i.row_index;
          col_d = in_item_i.col_index;
          k_d   = '0;
          case (in_item_i.command)
            CMD_WRITE_A: a_we_o = row_in_r && col_in_k;
            CMD_WRITE_B: b_we_o = row_in_k && col_in_c;
            CMD_READ_C: begin
              mac_ctl_o.clear = 1'b1;
              if (!(row_in_r && col_in_c)) begin
                err_d   = 1'b1;
                state_d = ST_DONE;
              end else begin
                err_d   = 1'b0;
                // An empty inner dimension sums to zero.
                state_d = (nk_i == '0) ? ST_DRAIN : ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        rd_en_o = 1'b1;
        if (last_k) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !mul_v_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          load_out_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`include "matrix_product_engine_assert.svh"

  `MPE_ASSERT_NOW(a_mul_follows_read, mul_v_q, $past(rd_v_q), "product stage without a read")
  `MPE_ASSERT_NOW(a_done_drained, state_q == ST_DONE, !rd_v_q && !mul_v_q, "result before drain")
  `MPE_ASSERT_NOW(a_no_write_busy, in_stall_o, !a_we_o && !b_we_o, "store write while busy")

endmodule

// ===== rtl/matrix_product_engine.sv =====
// Top level of the matrix product engine: config, stores, sequencer, output register.
`timescale 1ns / 1ps
// Computes one element C[row][col] of the dense product C = A x B in signed
// Q16.16 per read item, from A and B held in two internal stores that write
// items fill. A write item produces no result; writes outside the configured
// sizes are dropped. A read item inside the sizes sums over the clamped inner
// dimension; with an empty inner dimension the sum is zero. One shared multiply-
// accumulate unit handles one term per cycle, behind a registered store read
// and a product register. A read outside the sizes returns zero with status 1.
// Each product is shifted right arithmetically by 16 and accumulated in a wide
// register; the sum is clamped to 32 bits with status 2 on overflow. Size
// registers above MAX_DIM act as MAX_DIM. in_stall_o is high while an item is
// at work; a finished result waits in the output register while new items are
// taken. Elements in use must be written before they are read. Size registers
// may change only while the block is idle.
module matrix_product_engine
  import mpe_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_idx_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ELEM_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  // Size registers, reset to 1.
  logic [SIZE_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic [SIZE_W-1:0] nr, nk, nc;

  // Store ports.
  logic                    a_we, b_we, rd_en;
  logic [ADDR_W-1:0]       waddr, a_raddr, b_raddr;
  logic signed [ELEM_W-1:0] elem;
  logic [DATA_WIDTH-1:0]   wdata, a_rdata, b_rdata;

  // Sequencer and MAC handoff.
  mac_ctl_t          mac_ctl;
  logic              load_out, err, sat, out_free;
  logic signed [31:0] sum;

  // Output register.
  logic      out_valid_q;
  out_item_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= SIZE_W'(1);
      inner_dim_q <= SIZE_W'(1);
      cols_b_q    <= SIZE_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS_A:    rows_a_q    <= cfg_data_i;
        CFG_INNER_DIM: inner_dim_q <= cfg_data_i;
        CFG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: ;  // drop writes to an unused index
      endcase
    end
  end

  // Clamp sizes to the store dimension.
  assign nr = eff_size(rows_a_q, MAX_DIM);
  assign nk = eff_size(inner_dim_q, MAX_DIM);
  assign nc = eff_size(cols_b_q, MAX_DIM);

  // Keep the low element bits and sign-extend them to the store width.
  assign elem  = signed'(in_item_i.element_value[ELEM_W-1:0]);
  assign wdata = DATA_WIDTH'(elem);

  mpe_seq #(
    .MAX_DIM(MAX_DIM)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .nr_i       (nr),
    .nk_i       (nk),
    .nc_i       (nc),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .a_we_o     (a_we),
    .b_we_o     (b_we),
    .waddr_o    (waddr),
    .rd_en_o    (rd_en),
    .a_raddr_o  (a_raddr),
    .b_raddr_o  (b_raddr),
    .mac_ctl_o  (mac_ctl),
    .load_out_o (load_out),
    .err_o      (err)
  );

  mpe_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mpe_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  mpe_mac #(
    .MAX_DIM   (MAX_DIM),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mac (
    .clk_i (clk_i),
    .a_i   (a_rdata),
    .b_i   (b_rdata),
    .ctl_i (mac_ctl),
    .sum_o (sum),
    .sat_o (sat)
  );

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (err) begin
        out_item_q.product_value <= '0;
        out_item_q.status        <= STATUS_RANGE;
      end else begin
        out_item_q.product_value <= sum;
        out_item_q.status        <= sat ? STATUS_SAT : STATUS_OK;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`include "matrix_product_engine_assert.svh"

  `MPE_ASSERT_NOW(a_range_is_zero, out_valid_o && out_item_o.status == STATUS_RANGE, out_item_o.product_value == 32'sd0, "range error with nonzero value")
  `MPE_ASSERT_NEXT(a_load_shows, load_out, out_valid_o, "loaded result not offered")

endmodule

// ===== verif/matrix_product_engine_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the matrix product engine: directed table, then random phases.
module matrix_product_engine_test;
  import mpe_pkg::*;

  localparam int DIM = MAX_DIM_DEF;
  // Leave a margin after the longest read before touching the sizes.
  localparam int SETTLE_CYCLES = DIM + 16;
  localparam int RANDOM_ITEMS = 1530;
  localparam int PHASE_ITEMS = 80;
  // The fourth command code does nothing; the package leaves it unnamed.
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_W-1:0]  cfg_idx_i = CFG_ROWS_A;
  logic [SIZE_W-1:0] cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  in_item_t          in_item_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_item_t         out_item_o;

  matrix_product_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // One row of the directed table: either a size write or an item, with the
  // result typed in by hand where it is obvious, else taken from the predictor.
  typedef struct {
    bit                is_size;
    logic [CFG_W-1:0]  reg_idx;
    logic [SIZE_W-1:0] reg_val;
    in_item_t          item;
    bit                typed;
    out_item_t         want;
  } step_t;

  // Shadow copy of both operand stores, plus which entries hold a value.
  logic signed [31:0] a_elems [DIM*DIM];
  logic signed [31:0] b_elems [DIM*DIM];
  bit                 a_known [DIM*DIM];
  bit                 b_known [DIM*DIM];
  logic [SIZE_W-1:0]  rows_reg = 5'd1;
  logic [SIZE_W-1:0]  inner_reg = 5'd1;
  logic [SIZE_W-1:0]  cols_reg = 5'd1;

  out_item_t expected_products[$];
  step_t     directed_steps[$];
  int        mismatch_count = 0;
  int        items_sent = 0;
  int        sender_idle_pct = 0;
  int        receiver_stall_pct = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Clamp a size register the way the block does: anything above DIM acts as DIM.
  function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v);
    return (int'(v) > DIM) ? DIM : int'(v);
  endfunction

  // Apply one item to the shadow stores and work out the product element it asks for.
  task automatic compute_product(input in_item_t it, output bit produces,
                                 output out_item_t res);
    int unsigned nr, nk, nc, addr, k;
    longint      acc;
    nr = clamp_size(rows_reg);
    nk = clamp_size(inner_reg);
    nc = clamp_size(cols_reg);
    produces = 1'b0;
    res = '0;
    case (it.command)
      CMD_WRITE_A: begin
        if (it.row_index < nr && it.col_index < nk) begin
          addr = it.row_index * DIM + it.col_index;
          a_elems[addr] = it.element_value;
          a_known[addr] = 1'b1;
        end
      end
      CMD_WRITE_B: begin
        if (it.row_index < nk && it.col_index < nc) begin
          addr = it.row_index * DIM + it.col_index;
          b_elems[addr] = it.element_value;
          b_known[addr] = 1'b1;
        end
      end
      CMD_READ_C: begin
        produces = 1'b1;
        if (it.row_index >= nr || it.col_index >= nc) begin
          res.status = STATUS_RANGE;
        end else begin
          acc = 0;
          // Floor-shift each Q32.32 product back to Q16.16 before summing.
          for (k = 0; k < nk; k++) begin
            acc += (longint'(a_elems[it.row_index * DIM + k]) *
                    longint'(b_elems[k * DIM + it.col_index])) >>> 16;
          end
          res.status = STATUS_OK;
          if (acc > 64'sd2147483647) begin
            acc = 64'sd2147483647;
            res.status = STATUS_SAT;
          end else if (acc < -64'sd2147483648) begin
            acc = -64'sd2147483648;
            res.status = STATUS_SAT;
          end
          res.product_value = acc[31:0];
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic in_item_t make_item(logic [1:0] cmd, int unsigned row, int unsigned col,
                                         logic [31:0] val);
    in_item_t it;
    it.command = cmd;
    it.row_index = row[3:0];
    it.col_index = col[3:0];
    it.element_value = val;
    return it;
  endfunction

  function automatic step_t item_row(logic [1:0] cmd, int unsigned row, int unsigned col,
                                     logic [31:0] val);
    step_t s;
    s = '{default: '0};
    s.item = make_item(cmd, row, col, val);
    return s;
  endfunction

  function automatic step_t read_row(int unsigned row, int unsigned col, logic [31:0] prod,
                                     logic [1:0] stat);
    step_t s;
    s = item_row(CMD_READ_C, row, col, 32'h0);
    s.typed = 1'b1;
    s.want.product_value = prod;
    s.want.status = stat;
    return s;
  endfunction

  function automatic step_t size_row(logic [CFG_W-1:0] idx, logic [SIZE_W-1:0] val);
    step_t s;
    s = '{default: '0};
    s.is_size = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  // Mostly small Q16.16 values so sums stay exact, with some wide and extreme ones.
  function automatic logic [31:0] random_value();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
      1, 2: return $urandom();
      3, 4: return 32'(int'($urandom_range(0, 2 ** 25)) - 2 ** 24);
      default: return 32'(int'($urandom_range(0, 2 ** 19)) - 2 ** 18);
    endcase
  endfunction

  // Stay inside the given dimension most of the time; otherwise anywhere in the field.
  function automatic int unsigned pick_index(int unsigned limit);
    if (limit > 0 && $urandom_range(99) < 85) begin
      return $urandom_range(limit - 1);
    end
    return $urandom_range(15);
  endfunction

  function automatic logic [SIZE_W-1:0] random_size();
    case ($urandom_range(19))
      0: return 5'd0;
      1, 2: return SIZE_W'($urandom_range(17, 31));
      3, 4, 5: return SIZE_W'($urandom_range(7, 16));
      default: return SIZE_W'($urandom_range(1, 6));
    endcase
  endfunction

  // Offer one item after a random gap, hold it until taken, then record its result.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    bit        produces;
    out_item_t predicted;
    int        gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    compute_product(it, produces, predicted);
    if (produces) begin
      expected_products.push_back(typed ? want : predicted);
    end
    items_sent++;
  endtask

  // Drop valid, drain every pending result, then let a trailing write finish.
  task automatic halt_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] idx, input logic [SIZE_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ROWS_A:    rows_reg = val;
      CFG_INNER_DIM: inner_reg = val;
      CFG_COLS_B:    cols_reg = val;
      default: ;
    endcase
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Compare every result taken against the oldest outstanding expectation.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_products.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h status %0d",
                                  out_item_o.product_value, out_item_o.status));
      end else begin
        want = expected_products.pop_front();
        if (out_item_o.product_value !== want.product_value) begin
          report_mismatch($sformatf("product_value %h, want %h",
                                    out_item_o.product_value, want.product_value));
        end
        if (out_item_o.status !== want.status) begin
          report_mismatch($sformatf("status %0d, want %0d", out_item_o.status, want.status));
        end
      end
    end
  end

  initial begin : stimulus
    step_t        s;
    in_item_t     it;
    out_item_t    none;
    int           phase;
    int           pick;
    int           random_goal;
    int unsigned  nr, nk, nc, row, col, k;
    logic [31:0]  val;

    none = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, all at reset sizes 1 x 1 x 1 until the last rows.
    // Reads outside the sizes.
    directed_steps.push_back(read_row(1, 0, 32'h0, STATUS_RANGE));
    directed_steps.push_back(read_row(0, 15, 32'h0, STATUS_RANGE));
    // Saturation high, low, and from two most-negative operands.
    directed_steps.push_back(item_row(CMD_WRITE_A, 0, 0, 32'h7FFF_FFFF));
    directed_steps.push_back(item_row(CMD_WRITE_B, 0, 0, 32'h7FFF_FFFF));
    directed_steps.push_back(read_row(0, 0, 32'h7FFF_FFFF, STATUS_SAT));
    directed_steps.push_back(item_row(CMD_WRITE_B, 0, 0, 32'h8000_0000));
    directed_steps.push_back(read_row(0, 0, 32'h8000_0000, STATUS_SAT));
    directed_steps.push_back(item_row(CMD_WRITE_A, 0, 0, 32'h8000_0000));
    directed_steps.push_back(read_row(0, 0, 32'h7FFF_FFFF, STATUS_SAT));
    // 1.0 times 2.0.
    directed_steps.push_back(item_row(CMD_WRITE_A, 0, 0, 32'h0001_0000));
    directed_steps.push_back(item_row(CMD_WRITE_B, 0, 0, 32'h0002_0000));
    directed_steps.push_back(read_row(0, 0, 32'h0002_0000, STATUS_OK));
    // Tiny negative product rounds toward minus infinity, not to zero.
    directed_steps.push_back(item_row(CMD_WRITE_A, 0, 0, 32'hFFFF_FFFF));
    directed_steps.push_back(item_row(CMD_WRITE_B, 0, 0, 32'h0000_0001));
    directed_steps.push_back(read_row(0, 0, 32'hFFFF_FFFF, STATUS_OK));
    // Writes outside the sizes and the unused command must leave the stores alone.
    directed_steps.push_back(item_row(CMD_WRITE_A, 1, 0, 32'h1234_5678));
    directed_steps.push_back(item_row(CMD_WRITE_B, 0, 1, 32'h1234_5678));
    directed_steps.push_back(item_row(CMD_NONE, 15, 15, 32'hFFFF_FFFF));
    directed_steps.push_back(item_row(CMD_READ_C, 0, 0, 32'hFFFF_FFFF));
    // Empty inner dimension sums to zero; empty row count rejects every read.
    directed_steps.push_back(size_row(CFG_INNER_DIM, 5'd0));
    directed_steps.push_back(read_row(0, 0, 32'h0, STATUS_OK));
    directed_steps.push_back(size_row(CFG_ROWS_A, 5'd0));
    directed_steps.push_back(read_row(0, 0, 32'h0, STATUS_RANGE));

    foreach (directed_steps[i]) begin
      s = directed_steps[i];
      if (s.is_size) begin
        halt_input();
        set_size(s.reg_idx, s.reg_val);
      end else begin
        send_item(s.item, s.typed, s.want);
      end
    end

    // Random phases: extremes of the sizes first, then random sizes; the
    // idling pattern rotates through none, sender, receiver, both.
    random_goal = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < random_goal) begin
      halt_input();
      case (phase)
        0: begin set_size(CFG_ROWS_A, 5'd16); set_size(CFG_INNER_DIM, 5'd16);
                 set_size(CFG_COLS_B, 5'd16); end
        1: begin set_size(CFG_ROWS_A, 5'd31); set_size(CFG_INNER_DIM, 5'd17);
                 set_size(CFG_COLS_B, 5'd20); end
        2: begin set_size(CFG_ROWS_A, 5'd0); set_size(CFG_INNER_DIM, 5'd3);
                 set_size(CFG_COLS_B, 5'd3); end
        3: begin set_size(CFG_ROWS_A, 5'd3); set_size(CFG_INNER_DIM, 5'd0);
                 set_size(CFG_COLS_B, 5'd3); end
        4: begin set_size(CFG_ROWS_A, 5'd3); set_size(CFG_INNER_DIM, 5'd3);
                 set_size(CFG_COLS_B, 5'd0); end
        5: begin set_size(CFG_ROWS_A, 5'd1); set_size(CFG_INNER_DIM, 5'd16);
                 set_size(CFG_COLS_B, 5'd1); end
        6: begin set_size(CFG_ROWS_A, 5'd16); set_size(CFG_INNER_DIM, 5'd1);
                 set_size(CFG_COLS_B, 5'd16); end
        7: begin set_size(CFG_ROWS_A, 5'd1); set_size(CFG_INNER_DIM, 5'd1);
                 set_size(CFG_COLS_B, 5'd1); end
        default: begin
          set_size(CFG_ROWS_A, random_size());
          set_size(CFG_INNER_DIM, random_size());
          set_size(CFG_COLS_B, random_size());
        end
      endcase
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
        default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
      endcase
      nr = clamp_size(rows_reg);
      nk = clamp_size(inner_reg);
      nc = clamp_size(cols_reg);

      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(99);
        val = random_value();
        if (pick < 5) begin
          it = make_item(CMD_NONE, $urandom_range(15), $urandom_range(15), val);
        end else if (pick < 35) begin
          it = make_item(CMD_WRITE_A, pick_index(nr), pick_index(nk), val);
        end else if (pick < 62) begin
          it = make_item(CMD_WRITE_B, pick_index(nk), pick_index(nc), val);
        end else begin
          row = pick_index(nr);
          col = pick_index(nc);
          // Fill any operand the read would use that was never written.
          if (row < nr && col < nc) begin
            for (k = 0; k < nk; k++) begin
              if (!a_known[row * DIM + k]) begin
                send_item(make_item(CMD_WRITE_A, row, k, random_value()), 1'b0, none);
              end
              if (!b_known[k * DIM + col]) begin
                send_item(make_item(CMD_WRITE_B, k, col, random_value()), 1'b0, none);
              end
            end
          end
          it = make_item(CMD_READ_C, row, col, val);
        end
        send_item(it, 1'b0, none);
      end
      phase++;
    end

    halt_input();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
